// ----- rtl/kfsi_pkg.sv -----
// Package for the keyframe scale interpolator: widths, opcodes, status codes,
// the carried sideband type and one restoring division step. Depends on nothing.
package kfsi_pkg;

   localparam int MAX_KEYS   = 8;
   localparam int KEY_IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int KEY_CNT_W  = $clog2(MAX_KEYS + 1);
   localparam int TIME_W     = 17;
   localparam int SCALE_W    = 16;
   localparam int DIM_W      = 16;
   localparam int OUT_W      = 24;
   localparam int ACC_W      = 33;
   localparam int QUO_W      = 16;
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = QUO_W / DIV_BITS;

   localparam logic [SCALE_W-1:0] ONE_SCALE = 16'd256;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_EVAL   = 2'd2;
   // Opcode with no function: it changes nothing and returns an all-zero result.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // Fields that ride alongside the arithmetic from entry to output.
   typedef struct packed {
      logic               interp;
      logic [1:0]         status;
      logic [SCALE_W-1:0] sx;
      logic [SCALE_W-1:0] sy;
      logic [DIM_W-1:0]   bw;
      logic [DIM_W-1:0]   bh;
   } side_type;

   // One restoring division step: returns {quotient bit, new remainder}.
   function automatic logic [TIME_W:0] div_step(input logic [TIME_W-1:0] rem,
                                                input logic bit_in,
                                                input logic [TIME_W-1:0] den);
      logic [TIME_W:0] trial;
      logic [TIME_W:0] diff;
      trial = {rem, bit_in};
      diff  = trial - {1'b0, den};
      if (trial >= {1'b0, den}) begin
         div_step = {1'b1, diff[TIME_W-1:0]};
      end else begin
         div_step = {1'b0, trial[TIME_W-1:0]};
      end
   endfunction

endpackage

// ----- rtl/keyframe_scale_interpolator.sv -----
// Top level of the keyframe scale interpolator: keyframe table, search,
// blend multipliers, pipelined divider and output scaling. Uses kfsi_pkg.
//
//   Channel   Direction  Handshake               Payload
//   req_      in         req_valid / req_ready   opcode, key and particle fields
//   rsp_      out        rsp_valid / rsp_ready   scaled sizes, scales, status
//
// One item can enter per cycle while the pipeline advances. A result passes through four
// stages of search and blend, eight divider stages that resolve two quotient bits each, and
// two stages for the size products and saturation. Clear and append update the table at
// their transfer, so later evaluations see them in order. The whole pipeline advances
// whenever the output register is empty or being drained, else every stage holds. Reset
// empties the pipeline and loads the table with one key at time zero and scale 1.0.
module keyframe_scale_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [16:0] req_key_time,
   input  logic [15:0] req_key_scale_x,
   input  logic [15:0] req_key_scale_y,
   input  logic [16:0] req_particle_time,
   input  logic [15:0] req_begin_width,
   input  logic [15:0] req_begin_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_scaled_width,
   output logic [23:0] rsp_scaled_height,
   output logic [15:0] rsp_scale_x,
   output logic [15:0] rsp_scale_y,
   output logic [1:0]  rsp_status
);

   localparam int TW = kfsi_pkg::TIME_W;
   localparam int SW = kfsi_pkg::SCALE_W;
   localparam int NK = kfsi_pkg::MAX_KEYS;
   localparam int DS = kfsi_pkg::DIV_STAGES;
   localparam int QW = kfsi_pkg::QUO_W;
   localparam int AW = kfsi_pkg::ACC_W;

   // Keyframe table.
   logic [TW-1:0] key_time_ff [NK];
   logic [SW-1:0] key_sx_ff   [NK];
   logic [SW-1:0] key_sy_ff   [NK];
   logic [kfsi_pkg::KEY_CNT_W-1:0] key_count_ff;

   logic adv;
   logic take;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;
   assign take      = req_valid && adv;

   // Entry search: first stored key whose time exceeds the particle time.
   logic [kfsi_pkg::KEY_CNT_W-1:0] hit_idx;
   logic                           hit_found;
   logic [TW-1:0] tb_sel, ta_sel;
   logic [SW-1:0] sbx_sel, sax_sel, sby_sel, say_sel;
   kfsi_pkg::side_type side_new;

   always_comb begin
      hit_idx   = key_count_ff;
      hit_found = 1'b0;
      for (int k = 0; k < NK; k++) begin
         if (!hit_found && (k < int'(key_count_ff)) && (key_time_ff[k] > req_particle_time)) begin
            hit_found = 1'b1;
            hit_idx   = kfsi_pkg::KEY_CNT_W'(k);
         end
      end
      tb_sel = '0; ta_sel = '0;
      sbx_sel = '0; sax_sel = '0; sby_sel = '0; say_sel = '0;
      for (int k = 0; k < NK; k++) begin
         if (kfsi_pkg::KEY_CNT_W'(k) == hit_idx) begin
            ta_sel = key_time_ff[k]; sax_sel = key_sx_ff[k]; say_sel = key_sy_ff[k];
         end
         if (kfsi_pkg::KEY_CNT_W'(k + 1) == hit_idx) begin
            tb_sel = key_time_ff[k]; sbx_sel = key_sx_ff[k]; sby_sel = key_sy_ff[k];
         end
      end

      side_new = '0;
      if (req_opcode == kfsi_pkg::OP_APPEND) begin
         if (int'(key_count_ff) >= NK) begin
            side_new.status = kfsi_pkg::ST_FULL;
         end
      end else if (req_opcode == kfsi_pkg::OP_EVAL) begin
         side_new.bw = req_begin_width;
         side_new.bh = req_begin_height;
         if (key_count_ff == '0) begin
            side_new.status = kfsi_pkg::ST_EMPTY;
            side_new.sx     = kfsi_pkg::ONE_SCALE;
            side_new.sy     = kfsi_pkg::ONE_SCALE;
         end else if (hit_idx == '0) begin
            side_new.sx = sax_sel;
            side_new.sy = say_sel;
         end else if (hit_idx == key_count_ff) begin
            // Past the last key: the key before the hit is the last key.
            side_new.sx = sbx_sel;
            side_new.sy = sby_sel;
         end else begin
            side_new.interp = 1'b1;
         end
      end
   end

   // Table updates at the transfer of clear and append items.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= kfsi_pkg::KEY_CNT_W'(1);
         for (int k = 0; k < NK; k++) begin
            key_time_ff[k] <= '0;
            key_sx_ff[k]   <= kfsi_pkg::ONE_SCALE;
            key_sy_ff[k]   <= kfsi_pkg::ONE_SCALE;
         end
      end else if (take) begin
         if (req_opcode == kfsi_pkg::OP_CLEAR) begin
            key_count_ff <= '0;
         end else if (req_opcode == kfsi_pkg::OP_APPEND && int'(key_count_ff) < NK) begin
            key_time_ff[key_count_ff[kfsi_pkg::KEY_IDX_W-1:0]] <= req_key_time;
            key_sx_ff[key_count_ff[kfsi_pkg::KEY_IDX_W-1:0]]   <= req_key_scale_x;
            key_sy_ff[key_count_ff[kfsi_pkg::KEY_IDX_W-1:0]]   <= req_key_scale_y;
            key_count_ff <= key_count_ff + 1'b1;
         end
      end
   end

   // Stage 1: selected keys.
   logic v1_ff, v2_ff, v3_ff, v4_ff, vm_ff;
   kfsi_pkg::side_type side1_ff, side2_ff, side3_ff, side4_ff, sidem_ff;
   logic [TW-1:0] t1_ff, tb1_ff, ta1_ff;
   logic [SW-1:0] sbx1_ff, sax1_ff, sby1_ff, say1_ff;
   // Stage 2: span and offsets.
   logic [TW-1:0] den2_ff, num2_ff, rest2_ff;
   logic [SW-1:0] sbx2_ff, sax2_ff, sby2_ff, say2_ff;
   // Stage 3: weighted products.
   logic [TW-1:0] den3_ff;
   logic [SW+TW-1:0] pbx3_ff, pax3_ff, pby3_ff, pay3_ff;
   // Stage 4: rounded numerators.
   logic [TW-1:0] den4_ff;
   logic [AW-1:0] accx4_ff, accy4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= take; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff <= side_new;
         t1_ff    <= req_particle_time;
         tb1_ff   <= tb_sel;   ta1_ff  <= ta_sel;
         sbx1_ff  <= sbx_sel;  sax1_ff <= sax_sel;
         sby1_ff  <= sby_sel;  say1_ff <= say_sel;

         side2_ff <= side1_ff;
         den2_ff  <= ta1_ff - tb1_ff;
         num2_ff  <= t1_ff - tb1_ff;
         rest2_ff <= ta1_ff - t1_ff;
         sbx2_ff  <= sbx1_ff; sax2_ff <= sax1_ff;
         sby2_ff  <= sby1_ff; say2_ff <= say1_ff;

         side3_ff <= side2_ff;
         den3_ff  <= den2_ff;
         pbx3_ff  <= sbx2_ff * rest2_ff;
         pax3_ff  <= sax2_ff * num2_ff;
         pby3_ff  <= sby2_ff * rest2_ff;
         pay3_ff  <= say2_ff * num2_ff;

         side4_ff <= side3_ff;
         den4_ff  <= den3_ff;
         accx4_ff <= AW'(pbx3_ff) + AW'(pax3_ff) + AW'(den3_ff >> 1);
         accy4_ff <= AW'(pby3_ff) + AW'(pay3_ff) + AW'(den3_ff >> 1);
      end
   end

   // Divider: two quotient bits per stage. The quotient fits in 16 bits because
   // the numerator stays below 65536 times the span.
   logic               vd_ff    [DS];
   kfsi_pkg::side_type sided_ff [DS];
   logic [TW-1:0]      dend_ff  [DS];
   logic [TW-1:0]      remx_ff  [DS], remy_ff [DS];
   logic [QW-1:0]      lowx_ff  [DS], lowy_ff [DS];
   logic [QW-1:0]      quox_ff  [DS], quoy_ff [DS];

   for (genvar s = 0; s < DS; s++) begin : g_div
      logic               v_prev;
      kfsi_pkg::side_type side_prev;
      logic [TW-1:0]      den_prev, rx_prev, ry_prev;
      logic [QW-1:0]      lx_prev, ly_prev, qx_prev, qy_prev;
      logic [TW:0]        sx1, sx2, sy1, sy2;

      if (s == 0) begin : g_first
         assign v_prev    = v4_ff;
         assign side_prev = side4_ff;
         assign den_prev  = den4_ff;
         assign rx_prev   = accx4_ff[AW-1:QW];
         assign ry_prev   = accy4_ff[AW-1:QW];
         assign lx_prev   = accx4_ff[QW-1:0];
         assign ly_prev   = accy4_ff[QW-1:0];
         assign qx_prev   = '0;
         assign qy_prev   = '0;
      end else begin : g_next
         assign v_prev    = vd_ff[s-1];
         assign side_prev = sided_ff[s-1];
         assign den_prev  = dend_ff[s-1];
         assign rx_prev   = remx_ff[s-1];
         assign ry_prev   = remy_ff[s-1];
         assign lx_prev   = lowx_ff[s-1];
         assign ly_prev   = lowy_ff[s-1];
         assign qx_prev   = quox_ff[s-1];
         assign qy_prev   = quoy_ff[s-1];
      end

      assign sx1 = kfsi_pkg::div_step(rx_prev, lx_prev[QW-1], den_prev);
      assign sx2 = kfsi_pkg::div_step(sx1[TW-1:0], lx_prev[QW-2], den_prev);
      assign sy1 = kfsi_pkg::div_step(ry_prev, ly_prev[QW-1], den_prev);
      assign sy2 = kfsi_pkg::div_step(sy1[TW-1:0], ly_prev[QW-2], den_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[s] <= 1'b0;
         end else if (adv) begin
            vd_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sided_ff[s] <= side_prev;
            dend_ff[s]  <= den_prev;
            remx_ff[s]  <= sx2[TW-1:0];
            remy_ff[s]  <= sy2[TW-1:0];
            lowx_ff[s]  <= {lx_prev[QW-3:0], 2'b00};
            lowy_ff[s]  <= {ly_prev[QW-3:0], 2'b00};
            quox_ff[s]  <= {qx_prev[QW-3:0], sx1[TW], sx2[TW]};
            quoy_ff[s]  <= {qy_prev[QW-3:0], sy1[TW], sy2[TW]};
         end
      end
   end

   // Final scale choice and size products, then rounding and saturation.
   logic [SW-1:0]    fsx, fsy;
   logic [SW-1:0]    sxm_ff, sym_ff;
   logic [2*SW-1:0]  pw_ff, ph_ff;
   logic [2*SW:0]    rw, rh;
   logic [2*SW-8:0]  rw_sh, rh_sh;
   logic             rsp_valid_ff;
   logic [kfsi_pkg::OUT_W-1:0] w_ff, h_ff;
   logic [15:0]      osx_ff, osy_ff;
   logic [1:0]       ost_ff;

   assign fsx = sided_ff[DS-1].interp ? quox_ff[DS-1] : sided_ff[DS-1].sx;
   assign fsy = sided_ff[DS-1].interp ? quoy_ff[DS-1] : sided_ff[DS-1].sy;

   assign rw    = {1'b0, pw_ff} + (2*SW+1)'(128);
   assign rh    = {1'b0, ph_ff} + (2*SW+1)'(128);
   assign rw_sh = rw[2*SW:8];
   assign rh_sh = rh[2*SW:8];

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vm_ff        <= vd_ff[DS-1];
         rsp_valid_ff <= vm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sidem_ff <= sided_ff[DS-1];
         sxm_ff   <= fsx;
         sym_ff   <= fsy;
         pw_ff    <= sided_ff[DS-1].bw * fsx;
         ph_ff    <= sided_ff[DS-1].bh * fsy;

         w_ff   <= (rw_sh[2*SW-8] == 1'b1) ? 24'hFF_FFFF : rw_sh[23:0];
         h_ff   <= (rh_sh[2*SW-8] == 1'b1) ? 24'hFF_FFFF : rh_sh[23:0];
         osx_ff <= sxm_ff;
         osy_ff <= sym_ff;
         ost_ff <= sidem_ff.status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scaled_width  = w_ff;
   assign rsp_scaled_height = h_ff;
   assign rsp_scale_x       = osx_ff;
   assign rsp_scale_y       = osy_ff;
   assign rsp_status        = ost_ff;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      int'(key_count_ff) <= NK) else $error("key count beyond table depth");
   a_empty_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == kfsi_pkg::ST_EMPTY |-> rsp_scale_x == kfsi_pkg::ONE_SCALE
      && rsp_scale_y == kfsi_pkg::ONE_SCALE) else $error("empty table scale not 1.0");
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == kfsi_pkg::ST_FULL |-> rsp_scaled_width == '0
      && rsp_scale_x == '0) else $error("rejected append carries data");
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      take && req_opcode == kfsi_pkg::OP_CLEAR |=> key_count_ff == '0)
      else $error("clear did not empty the table");
`endif

endmodule

// ----- dv/tb_keyframe_scale_interpolator.sv -----
// Self-checking testbench for the keyframe scale interpolator: directed and random
// clear, append and evaluate transfers, checked against an in-bench table model.
// Depends on kfsi_pkg and rtl/keyframe_scale_interpolator.sv.
`timescale 1ns / 1ps

module tb_keyframe_scale_interpolator;

   // One request as it travels over the req_ channel.
   typedef struct packed {
      logic [1:0]  opcode;
      logic [16:0] key_time;
      logic [15:0] key_scale_x;
      logic [15:0] key_scale_y;
      logic [16:0] particle_time;
      logic [15:0] begin_width;
      logic [15:0] begin_height;
   } request_type;

   // One result as it appears on the rsp_ channel.
   typedef struct packed {
      logic [23:0] scaled_width;
      logic [23:0] scaled_height;
      logic [15:0] scale_x;
      logic [15:0] scale_y;
      logic [1:0]  status;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = kfsi_pkg::OP_CLEAR;
   logic [16:0] req_key_time = '0;
   logic [15:0] req_key_scale_x = '0;
   logic [15:0] req_key_scale_y = '0;
   logic [16:0] req_particle_time = '0;
   logic [15:0] req_begin_width = '0;
   logic [15:0] req_begin_height = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_scaled_width;
   logic [23:0] rsp_scaled_height;
   logic [15:0] rsp_scale_x;
   logic [15:0] rsp_scale_y;
   logic [1:0]  rsp_status;

   keyframe_scale_interpolator dut (.*);

   always #6 clock = ~clock;

   // The bench's own copy of the keyframe table. Entries at or above the key
   // count are never read, so they need no reset value.
   logic [16:0] table_time [kfsi_pkg::MAX_KEYS];
   logic [15:0] table_sx [kfsi_pkg::MAX_KEYS];
   logic [15:0] table_sy [kfsi_pkg::MAX_KEYS];
   int          table_count;

   request_type pending_requests[$];
   result_type  expected_results[$];
   int       error_count = 0;
   bit       stimulus_done = 1'b0;
   bit       quiet_phase = 1'b0;   // no idling on either side in the closing stretch
   bit       hold_sender = 1'b0;   // the sender holds off until the pipeline drains
   bit       req_sent = 1'b0;      // set by the monitor when the presented request transfers

   // Adds one request at the tail of the pending queue.
   function automatic void queue_request(input request_type rq);
      pending_requests = {pending_requests, rq};
   endfunction

   // Linear blend between two keys, rounded to nearest with ties going up.
   function automatic logic [15:0] blend(input logic [15:0] s_lo, input logic [15:0] s_hi,
                                         input logic [16:0] t_lo, input logic [16:0] t_hi,
                                         input logic [16:0] t);
      logic [63:0] span;
      logic [63:0] offset;
      logic [63:0] acc;
      span   = 64'(t_hi - t_lo);
      offset = 64'(t - t_lo);
      acc    = 64'(s_lo) * (span - offset) + 64'(s_hi) * offset + span / 2;
      return 16'(acc / span);
   endfunction

   // Size times scale in Q8.8, rounded and saturated to 24 bits.
   function automatic logic [23:0] scale_size(input logic [15:0] size, input logic [15:0] scale);
      logic [63:0] prod;
      prod = (64'(size) * 64'(scale) + 64'd128) >> 8;
      return (prod > 64'hFFFFFF) ? 24'hFFFFFF : prod[23:0];
   endfunction

   // Applies one accepted request to the table model and returns its result.
   function automatic result_type interpolate_request(input request_type rq);
      result_type r;
      int      i;
      r = '0;
      unique case (rq.opcode)
         kfsi_pkg::OP_CLEAR: begin
            table_count = 0;
         end
         kfsi_pkg::OP_APPEND: begin
            if (table_count < kfsi_pkg::MAX_KEYS) begin
               table_time[table_count] = rq.key_time;
               table_sx[table_count]   = rq.key_scale_x;
               table_sy[table_count]   = rq.key_scale_y;
               table_count++;
            end else begin
               r.status = kfsi_pkg::ST_FULL;
            end
         end
         kfsi_pkg::OP_EVAL: begin
            if (table_count == 0) begin
               r.scale_x = kfsi_pkg::ONE_SCALE;
               r.scale_y = kfsi_pkg::ONE_SCALE;
               r.status  = kfsi_pkg::ST_EMPTY;
            end else begin
               i = 0;
               while (i < table_count && table_time[i] <= rq.particle_time) i++;
               if (i == table_count) begin
                  r.scale_x = table_sx[table_count-1];
                  r.scale_y = table_sy[table_count-1];
               end else if (i == 0) begin
                  r.scale_x = table_sx[0];
                  r.scale_y = table_sy[0];
               end else begin
                  r.scale_x = blend(table_sx[i-1], table_sx[i], table_time[i-1],
                                    table_time[i], rq.particle_time);
                  r.scale_y = blend(table_sy[i-1], table_sy[i], table_time[i-1],
                                    table_time[i], rq.particle_time);
               end
            end
            r.scaled_width  = scale_size(rq.begin_width, r.scale_x);
            r.scaled_height = scale_size(rq.begin_height, r.scale_y);
         end
         default: ;
      endcase
      return r;
   endfunction

   // Request builders used by the stimulus. Fields an opcode ignores carry noise.
   function automatic request_type random_request();
      logic [127:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom};
      return noise[$bits(request_type)-1:0];
   endfunction

   function automatic request_type make_key(input logic [16:0] t, input logic [15:0] sx,
                                            input logic [15:0] sy);
      request_type rq;
      rq = random_request();
      rq.opcode = kfsi_pkg::OP_APPEND;
      rq.key_time = t;
      rq.key_scale_x = sx;
      rq.key_scale_y = sy;
      return rq;
   endfunction

   function automatic request_type make_eval(input logic [16:0] t, input logic [15:0] w,
                                             input logic [15:0] h);
      request_type rq;
      rq = random_request();
      rq.opcode = kfsi_pkg::OP_EVAL;
      rq.particle_time = t;
      rq.begin_width = w;
      rq.begin_height = h;
      return rq;
   endfunction

   function automatic request_type make_op(input logic [1:0] op);
      request_type rq;
      rq = random_request();
      rq.opcode = op;
      return rq;
   endfunction

   function automatic logic [16:0] random_time();
      case ($urandom_range(0, 5))
         0: return 17'd0;
         1: return 17'd65536;
         2: return 17'($urandom_range(0, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic logic [15:0] random_word();
      case ($urandom_range(0, 4))
         0: return 16'hFFFF;
         1: return 16'd0;
         2: return 16'($urandom_range(0, 1023));
         default: return 16'($urandom);
      endcase
   endfunction

   // Driver: presents the oldest pending request, changing inputs on the falling
   // edge, with random idle bursts unless the closing stretch or a hold-off applies.
   int sender_idle = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_sent) begin
            // Hold the payload until the transfer completes.
         end else begin
            if (req_sent) begin
               // The transfer happened at the last rising edge; the monitor predicted it.
               void'(pending_requests.pop_front());
               req_sent = 1'b0;
            end
            if (hold_sender || pending_requests.size() == 0) begin
               req_valid <= 1'b0;
            end else if (sender_idle > 0) begin
               sender_idle--;
               req_valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
               sender_idle = $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else begin
               req_valid         <= 1'b1;
               req_opcode        <= pending_requests[0].opcode;
               req_key_time      <= pending_requests[0].key_time;
               req_key_scale_x   <= pending_requests[0].key_scale_x;
               req_key_scale_y   <= pending_requests[0].key_scale_y;
               req_particle_time <= pending_requests[0].particle_time;
               req_begin_width   <= pending_requests[0].begin_width;
               req_begin_height  <= pending_requests[0].begin_height;
            end
         end
      end
   end

   // Receiver stall pattern, also changed on the falling edge.
   int receiver_idle = 0;
   always @(negedge clock) begin
      if (quiet_phase) begin
         rsp_ready <= 1'b1;
      end else if (receiver_idle > 0) begin
         receiver_idle--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         receiver_idle = $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predicts every accepted request and checks every accepted result
   // at the rising edge.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_sent = 1'b1;
            expected_results = {expected_results, interpolate_request(request_type'({
               req_opcode, req_key_time, req_key_scale_x, req_key_scale_y,
               req_particle_time, req_begin_width, req_begin_height}))};
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_scaled_width, rsp_scaled_height, rsp_scale_x, rsp_scale_y, rsp_status};
            if (expected_results.size() == 0) begin
               $display("%0t: result with none expected, expected none actual %h", $time, got);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.scaled_width !== want.scaled_width) begin
                  $display("%0t: scaled_width expected %h actual %h", $time,
                           want.scaled_width, got.scaled_width);
                  error_count++;
               end
               if (got.scaled_height !== want.scaled_height) begin
                  $display("%0t: scaled_height expected %h actual %h", $time,
                           want.scaled_height, got.scaled_height);
                  error_count++;
               end
               if (got.scale_x !== want.scale_x) begin
                  $display("%0t: scale_x expected %h actual %h", $time,
                           want.scale_x, got.scale_x);
                  error_count++;
               end
               if (got.scale_y !== want.scale_y) begin
                  $display("%0t: scale_y expected %h actual %h", $time,
                           want.scale_y, got.scale_y);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status expected %h actual %h", $time,
                           want.status, got.status);
                  error_count++;
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      int n;
      int keys;
      logic [16:0] t;
      table_count = 1;
      table_time[0] = '0;
      table_sx[0] = kfsi_pkg::ONE_SCALE;
      table_sy[0] = kfsi_pkg::ONE_SCALE;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: the reset table, extremes of the sizes, empty table, a blend
      // segment, equal times, out-of-order keys, a full table and the unused opcode.
      queue_request(make_eval(17'd0, 16'hFFFF, 16'hFFFF));
      queue_request(make_eval(17'd65536, 16'd0, 16'd1));
      queue_request(make_op(kfsi_pkg::OP_CLEAR));
      queue_request(make_eval(17'd100, 16'h1234, 16'hFFFF));
      queue_request(make_key(17'd1000, 16'd0, 16'hFFFF));
      queue_request(make_key(17'd3000, 16'hFFFF, 16'd0));
      queue_request(make_eval(17'd999, 16'hFFFF, 16'hFFFF));
      queue_request(make_eval(17'd2000, 16'hFFFF, 16'hFFFF));
      queue_request(make_eval(17'd2999, 16'h8000, 16'h0001));
      queue_request(make_eval(17'd3000, 16'h00FF, 16'h0F0F));
      queue_request(make_key(17'd3000, 16'd512, 16'd128));
      queue_request(make_key(17'd500, 16'd300, 16'd700));
      queue_request(make_key(17'd65536, 16'd1, 16'd2));
      queue_request(make_key(17'h1FFFF, 16'd9, 16'd9));
      queue_request(make_key(17'd70000, 16'd5, 16'd5));
      queue_request(make_key(17'd70001, 16'd6, 16'd6));
      queue_request(make_key(17'd80000, 16'd7, 16'd7));
      queue_request(make_eval(17'd65535, 16'hFFFF, 16'h7777));
      queue_request(make_eval(17'h1FFFF, 16'h0010, 16'h0100));
      queue_request(make_op(kfsi_pkg::OP_UNUSED));
      queue_request(make_eval(17'd75000, 16'hABCD, 16'hDCBA));

      // Let the directed part drain fully before the random part starts.
      wait (pending_requests.size() == 0);
      hold_sender = 1'b1;
      wait (expected_results.size() == 0);
      hold_sender = 1'b0;

      // Random part: mostly a fresh table of a few keys in non-decreasing time
      // order followed by a run of evaluations, plus noise and full-table appends.
      n = 0;
      while (n < 1200) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_request(make_op(2'($urandom_range(0, 3))));
            n++;
         end else begin
            queue_request(make_op(kfsi_pkg::OP_CLEAR));
            keys = $urandom_range(0, kfsi_pkg::MAX_KEYS + 1);
            t = 17'($urandom_range(0, 8192));
            for (int k = 0; k < keys; k++) begin
               queue_request(make_key(t, random_word(), random_word()));
               t = ($urandom_range(0, 3) == 0) ? t : 17'(t + $urandom_range(1, 16384));
            end
            n += keys + 1;
            for (int e = $urandom_range(2, 12); e > 0; e--) begin
               queue_request(make_eval(random_time(), random_word(), random_word()));
               n++;
            end
         end
         if (n > 1000) quiet_phase = 1'b1;
         wait (pending_requests.size() < 20);
      end

      wait (pending_requests.size() == 0 && !req_valid);
      wait (expected_results.size() == 0);
      repeat (40) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("tb_keyframe_scale_interpolator: PASS");
      end else begin
         $display("tb_keyframe_scale_interpolator: FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_keyframe_scale_interpolator: FAIL");
      $finish;
   end

endmodule

// ----- keyframe_scale_interpolator.f -----
rtl/kfsi_pkg.sv
rtl/keyframe_scale_interpolator.sv
dv/tb_keyframe_scale_interpolator.sv
